FILE: hdl/lgs_pkg.sv
`timescale 1ns / 1ps

package lgs_pkg;

   // configuration port
   localparam int CSR_WIDTH       = 11;
   localparam int CSR_INDEX_WIDTH = 2;

   localparam logic [CSR_INDEX_WIDTH-1:0] REG_GRID_WIDTH  = 2'd0;
   localparam logic [CSR_INDEX_WIDTH-1:0] REG_GRID_HEIGHT = 2'd1;

   localparam int GRID_WIDTH_RESET  = 64;
   localparam int GRID_HEIGHT_RESET = 64;

   // grid limits
   localparam int MAX_WIDTH_DEFAULT  = 1024;
   localparam int MAX_HEIGHT_DEFAULT = 1024;

   // result coordinates
   localparam int COORD_WIDTH = 10;

   // request codes
   localparam logic OP_CELL  = 1'b0;
   localparam logic OP_FLUSH = 1'b1;

   // B3/S23
   localparam int BIRTH_COUNT   = 3;
   localparam int SURVIVE_COUNT = 2;

   // per-word control handed from the fetch stage to the window stage
   typedef struct packed {
      logic first_col;  // word sits in column 0
      logic row_ge1;    // middle row lies inside the grid
      logic row_ge2;    // upper row lies inside the grid
      logic last;       // word emits the final cell of the frame
   } stage_ctrl_type;

   // window: bits 0..2 left column, 3..5 centre, 6..8 right;
   // inside a column bit 0 is the upper row, bit 2 the lower row
   function automatic logic life_rule(input logic [8:0] win);
      logic [3:0] n;
      n = '0;
      for (int i = 0; i < 9; i++) begin
         if (i != 4) begin
            n = n + 4'(win[i]);
         end
      end
      return (n == 4'(BIRTH_COUNT)) ||
             (win[4] && ((n == 4'(SURVIVE_COUNT)) || (n == 4'(BIRTH_COUNT))));
   endfunction

endpackage

FILE: hdl/lgs_line_store.sv
`timescale 1ns / 1ps

module lgs_line_store #(
   parameter int DEPTH = lgs_pkg::MAX_WIDTH_DEFAULT,
   localparam int AW = $clog2(DEPTH)
) (
   input  logic          clock,
   input  logic          rd_en,
   input  logic [AW-1:0] rd_addr,
   input  logic          wr_en,
   input  logic [AW-1:0] wr_addr,
   input  logic          wr_upper,
   input  logic          wr_middle,
   output logic          upper_rd,
   output logic          middle_rd
);

   logic upper_mem [DEPTH];
   logic middle_mem [DEPTH];

   logic upper_rd_ff;
   logic middle_rd_ff;

   // write and read share a cycle at the same column only on a one-column grid
   // or back-to-back revisits; bypass the write data then
   always_ff @(posedge clock) begin
      if (wr_en) begin
         upper_mem[wr_addr]  <= wr_upper;
         middle_mem[wr_addr] <= wr_middle;
      end
      if (rd_en) begin
         if (wr_en && (wr_addr == rd_addr)) begin
            upper_rd_ff  <= wr_upper;
            middle_rd_ff <= wr_middle;
         end else begin
            upper_rd_ff  <= upper_mem[rd_addr];
            middle_rd_ff <= middle_mem[rd_addr];
         end
      end
   end

   assign upper_rd  = upper_rd_ff;
   assign middle_rd = middle_rd_ff;

endmodule

FILE: hdl/lgs_window.sv
`timescale 1ns / 1ps

module lgs_window (
   input  logic                   clock,
   input  logic                   reset,
   input  logic                   clear,
   input  logic                   advance,
   input  logic [2:0]             column,
   input  lgs_pkg::stage_ctrl_type ctrl,
   output logic                   emit,
   output logic                   result
);

   logic [8:0] window_ff;
   logic [8:0] window_in;
   logic [8:0] shifted;

   always_comb begin
      shifted = {column, window_ff[8:6], window_ff[5:3]};
      if (ctrl.first_col) begin
         window_in = {column, 6'b0};
         emit      = ctrl.row_ge2;
         // close the previous row: its right neighbour column is dead
         result    = lgs_pkg::life_rule({3'b0, window_ff[8:3]});
      end else begin
         window_in = shifted;
         emit      = ctrl.row_ge1;
         result    = lgs_pkg::life_rule(shifted);
      end
   end

   always_ff @(posedge clock) begin
      if (reset || clear) begin
         window_ff <= '0;
      end else if (advance) begin
         window_ff <= ctrl.last ? 9'b0 : window_in;
      end
   end

endmodule

FILE: hdl/life_generation_stream.sv
`timescale 1ns / 1ps

// channel   direction  handshake            payload
// req       in         req_valid/req_ready  req_op, req_alive
// rsp       out        rsp_valid/rsp_ready  rsp_next_alive, rsp_col, rsp_row, rsp_last
// csr       in         csr_write            csr_index, csr_wdata
//
// One word accepted per cycle unless a stalled rsp backs up the pipe. An accepted word is
// registered in stage 1 (line store data, then window and rule); its result loads the output
// register when stage 1 advances and leaves from there once rsp_ready is high.
// The line store has one read and one write port: a column is read while the previous
// column is written in the same cycle.
// Reset is synchronous and clears counters, window and valid flags; the line
// stores need no clearing pass because rows above the grid are masked as dead.
// A stalled rsp holds the pipe; req_ready drops only when stage 1 and the output
// register are both full and rsp_ready is low.
module life_generation_stream #(
   parameter int MAX_WIDTH  = lgs_pkg::MAX_WIDTH_DEFAULT,
   parameter int MAX_HEIGHT = lgs_pkg::MAX_HEIGHT_DEFAULT
) (
   input  logic                                 clock,
   input  logic                                 reset,
   // input words
   input  logic                                 req_valid,
   output logic                                 req_ready,
   input  logic                                 req_op,
   input  logic                                 req_alive,
   // result words
   output logic                                 rsp_valid,
   input  logic                                 rsp_ready,
   output logic                                 rsp_next_alive,
   output logic [lgs_pkg::COORD_WIDTH-1:0]      rsp_col,
   output logic [lgs_pkg::COORD_WIDTH-1:0]      rsp_row,
   output logic                                 rsp_last,
   // configuration
   input  logic                                 csr_write,
   input  logic [lgs_pkg::CSR_INDEX_WIDTH-1:0]  csr_index,
   input  logic [lgs_pkg::CSR_WIDTH-1:0]        csr_wdata
);

   localparam int AW   = $clog2(MAX_WIDTH);       // column index
   localparam int DW   = $clog2(MAX_WIDTH + 1);   // clamped width
   localparam int HW   = $clog2(MAX_HEIGHT + 1);  // clamped height
   localparam int RW   = $clog2(MAX_HEIGHT + 2);  // input row, runs to height + 1 while draining
   localparam int ORW  = $clog2(MAX_HEIGHT);      // output row
   localparam int CW   = lgs_pkg::CSR_WIDTH;
   localparam int CMPW = (CW >= DW && CW >= HW) ? CW : ((DW >= HW) ? DW : HW);

   function automatic logic [CMPW-1:0] clamp_dim(input logic [CW-1:0] v,
                                                 input logic [CMPW-1:0] maxv);
      logic [CMPW-1:0] ve;
      ve = CMPW'(v);
      if (ve == '0) begin
         return CMPW'(1);
      end else if (ve > maxv) begin
         return maxv;
      end
      return ve;
   endfunction

   // ---------------------------------------------------------------- config
   logic [DW-1:0] width_ff;
   logic [HW-1:0] height_ff;
   logic          cfg_restart;

   assign cfg_restart = csr_write &&
                        ((csr_index == lgs_pkg::REG_GRID_WIDTH) ||
                         (csr_index == lgs_pkg::REG_GRID_HEIGHT));

   always_ff @(posedge clock) begin
      if (reset) begin
         width_ff  <= DW'(clamp_dim(CW'(lgs_pkg::GRID_WIDTH_RESET), CMPW'(MAX_WIDTH)));
         height_ff <= HW'(clamp_dim(CW'(lgs_pkg::GRID_HEIGHT_RESET), CMPW'(MAX_HEIGHT)));
      end else if (csr_write) begin
         case (csr_index)
            lgs_pkg::REG_GRID_WIDTH: begin
               width_ff <= DW'(clamp_dim(csr_wdata, CMPW'(MAX_WIDTH)));
            end
            lgs_pkg::REG_GRID_HEIGHT: begin
               height_ff <= HW'(clamp_dim(csr_wdata, CMPW'(MAX_HEIGHT)));
            end
            default: begin
               // unmapped index: drop the write
            end
         endcase
      end
   end

   // ---------------------------------------------------------------- pipe control
   logic s1_valid_ff;
   logic rsp_valid_ff;
   logic out_free;
   logic s1_go;
   logic accept;
   logic ignore;
   logic take;

   assign out_free  = !rsp_valid_ff || rsp_ready;
   assign s1_go     = s1_valid_ff && out_free;
   assign req_ready = !s1_valid_ff || out_free;
   assign accept    = req_valid && req_ready;

   // ---------------------------------------------------------------- fetch stage
   logic [AW-1:0]  in_col_ff, in_col_in;
   logic [RW-1:0]  in_row_ff, in_row_in;
   logic           draining_ff, draining_in;
   logic [DW-1:0]  width_last;
   logic           row_end;
   logic           frame_end;
   logic           last_word;
   logic           cell_bit;
   lgs_pkg::stage_ctrl_type ctrl;

   assign width_last = width_ff - DW'(1);
   assign row_end    = (DW'(in_col_ff) == width_last);
   assign frame_end  = row_end && (in_row_ff == (RW'(height_ff) - RW'(1)));
   // the final cell of the frame comes out at column 0 two rows past its own
   assign last_word  = (in_col_ff == '0) && (in_row_ff == (RW'(height_ff) + RW'(1)));

   // flush outside draining is swallowed without touching anything
   assign ignore   = (req_op == lgs_pkg::OP_FLUSH) && !draining_ff;
   assign take     = accept && !ignore;
   // while draining every word is a flush and feeds a dead cell
   assign cell_bit = (req_op == lgs_pkg::OP_CELL) && !draining_ff && req_alive;

   always_comb begin
      ctrl.first_col = (in_col_ff == '0);
      ctrl.row_ge1   = (in_row_ff != '0);
      ctrl.row_ge2   = (in_row_ff > RW'(1));
      ctrl.last      = last_word;

      in_col_in   = in_col_ff;
      in_row_in   = in_row_ff;
      draining_in = draining_ff;
      if (last_word) begin
         // frame done: next word is cell (0,0)
         in_col_in   = '0;
         in_row_in   = '0;
         draining_in = 1'b0;
      end else begin
         if (frame_end) begin
            draining_in = 1'b1;
         end
         if (row_end) begin
            in_col_in = '0;
            in_row_in = in_row_ff + RW'(1);
         end else begin
            in_col_in = in_col_ff + AW'(1);
         end
      end
   end

   always_ff @(posedge clock) begin
      if (reset || cfg_restart) begin
         in_col_ff   <= '0;
         in_row_ff   <= '0;
         draining_ff <= 1'b0;
      end else if (take) begin
         in_col_ff   <= in_col_in;
         in_row_ff   <= in_row_in;
         draining_ff <= draining_in;
      end
   end

   // ---------------------------------------------------------------- stage 1
   logic [AW-1:0]           s1_col_ff;
   logic                    s1_cell_ff;
   lgs_pkg::stage_ctrl_type s1_ctrl_ff;
   logic                    upper_rd;
   logic                    middle_rd;
   logic                    s1_upper;
   logic                    s1_middle;
   logic                    emit;
   logic                    result;

   always_ff @(posedge clock) begin
      if (reset) begin
         s1_valid_ff <= 1'b0;
      end else if (take) begin
         s1_valid_ff <= 1'b1;
      end else if (s1_go) begin
         s1_valid_ff <= 1'b0;
      end
   end

   always_ff @(posedge clock) begin
      if (take) begin
         s1_col_ff  <= in_col_ff;
         s1_cell_ff <= cell_bit;
         s1_ctrl_ff <= ctrl;
      end
   end

   // rows above the top edge are dead; this also hides never-written entries
   assign s1_upper  = s1_ctrl_ff.row_ge2 && upper_rd;
   assign s1_middle = s1_ctrl_ff.row_ge1 && middle_rd;

   // stage 1 rewrites its column every cycle it sits here; the value is stable
   lgs_line_store #(
      .DEPTH (MAX_WIDTH)
   ) u_line_store (
      .clock     (clock),
      .rd_en     (take),
      .rd_addr   (in_col_ff),
      .wr_en     (s1_valid_ff),
      .wr_addr   (s1_col_ff),
      .wr_upper  (s1_middle),
      .wr_middle (s1_cell_ff),
      .upper_rd  (upper_rd),
      .middle_rd (middle_rd)
   );

   lgs_window u_window (
      .clock   (clock),
      .reset   (reset),
      .clear   (cfg_restart),
      .advance (s1_go),
      .column  ({s1_cell_ff, s1_middle, s1_upper}),
      .ctrl    (s1_ctrl_ff),
      .emit    (emit),
      .result  (result)
   );

   // ---------------------------------------------------------------- output register
   logic [AW-1:0]                   out_col_ff, out_col_in;
   logic [ORW-1:0]                  out_row_ff, out_row_in;
   logic                            rsp_next_alive_ff;
   logic [lgs_pkg::COORD_WIDTH-1:0] rsp_col_ff;
   logic [lgs_pkg::COORD_WIDTH-1:0] rsp_row_ff;
   logic                            rsp_last_ff;

   always_comb begin
      out_col_in = out_col_ff + AW'(1);
      out_row_in = out_row_ff;
      if (s1_ctrl_ff.last) begin
         out_col_in = '0;
         out_row_in = '0;
      end else if (DW'(out_col_ff) == width_last) begin
         out_col_in = '0;
         out_row_in = out_row_ff + ORW'(1);
      end
   end

   always_ff @(posedge clock) begin
      if (reset || cfg_restart) begin
         out_col_ff <= '0;
         out_row_ff <= '0;
      end else if (s1_go && emit) begin
         out_col_ff <= out_col_in;
         out_row_ff <= out_row_in;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         rsp_valid_ff <= 1'b0;
      end else if (s1_go && emit) begin
         rsp_valid_ff <= 1'b1;
      end else if (rsp_ready) begin
         rsp_valid_ff <= 1'b0;
      end
   end

   always_ff @(posedge clock) begin
      if (s1_go && emit) begin
         rsp_next_alive_ff <= result;
         rsp_col_ff        <= lgs_pkg::COORD_WIDTH'(out_col_ff);
         rsp_row_ff        <= lgs_pkg::COORD_WIDTH'(out_row_ff);
         rsp_last_ff       <= s1_ctrl_ff.last;
      end
   end

   assign rsp_valid      = rsp_valid_ff;
   assign rsp_next_alive = rsp_next_alive_ff;
   assign rsp_col        = rsp_col_ff;
   assign rsp_row        = rsp_row_ff;
   assign rsp_last       = rsp_last_ff;

endmodule

FILE: hdl/lgs_checker.sv
`timescale 1ns / 1ps

module lgs_checker (
   input logic                            clock,
   input logic                            reset,
   input logic                            req_ready,
   input logic                            rsp_valid,
   input logic                            rsp_ready,
   input logic                            rsp_next_alive,
   input logic [lgs_pkg::COORD_WIDTH-1:0] rsp_col,
   input logic [lgs_pkg::COORD_WIDTH-1:0] rsp_row,
   input logic                            rsp_last
);

   // nothing comes out of reset pending
   property p_reset_empty;
      @(posedge clock) reset |=> !rsp_valid;
   endproperty
   a_reset_empty: assert property (p_reset_empty)
      else $error("result valid right after reset");

   // a stalled result keeps its word
   property p_rsp_hold;
      @(posedge clock) disable iff (reset)
         rsp_valid && !rsp_ready |=>
            rsp_valid && $stable(rsp_next_alive) && $stable(rsp_col) &&
            $stable(rsp_row) && $stable(rsp_last);
   endproperty
   a_rsp_hold: assert property (p_rsp_hold)
      else $error("stalled result changed");

   // an empty output register never backs up the input
   property p_no_false_stall;
      @(posedge clock) !rsp_valid |-> req_ready;
   endproperty
   a_no_false_stall: assert property (p_no_false_stall)
      else $error("input stalled with empty output");

endmodule

bind life_generation_stream lgs_checker u_lgs_checker (.*);

FILE: tb/sv/life_generation_checker.sv
`timescale 1ns / 1ps

module life_generation_checker (
   input  logic                                clock,
   input  logic                                reset,
   input  logic                                req_valid,
   input  logic                                req_ready,
   input  logic                                req_op,
   input  logic                                req_alive,
   input  logic                                rsp_valid,
   input  logic                                rsp_ready,
   input  logic                                rsp_next_alive,
   input  logic [lgs_pkg::COORD_WIDTH-1:0]     rsp_col,
   input  logic [lgs_pkg::COORD_WIDTH-1:0]     rsp_row,
   input  logic                                rsp_last,
   input  logic                                csr_write,
   input  logic [lgs_pkg::CSR_INDEX_WIDTH-1:0] csr_index,
   input  logic [lgs_pkg::CSR_WIDTH-1:0]       csr_wdata,
   output int                                  mismatch_count,
   output int                                  pending_results
);
   import lgs_pkg::*;

   typedef struct packed {
      logic                   next_alive;
      logic [COORD_WIDTH-1:0] col;
      logic [COORD_WIDTH-1:0] row;
      logic                   last;
   } cell_result_type;

   cell_result_type next_gen_q[$];

   // shadow of the block: two line stores, the 3x3 window, raster positions
   bit                   upper_bits [MAX_WIDTH_DEFAULT];
   bit                   middle_bits [MAX_WIDTH_DEFAULT];
   logic [8:0]           win_bits;
   int unsigned          in_c, in_r, out_c, out_r;
   bit                   drain;
   logic [CSR_WIDTH-1:0] width_reg, height_reg;

   function automatic int unsigned span(input logic [CSR_WIDTH-1:0] v,
                                        input int unsigned limit);
      if (v == 0) return 1;
      if (v > limit) return limit;
      return 32'(v);
   endfunction

   // B3/S23 on a 9-bit window, centre at bit 4
   function automatic logic life_next(input logic [8:0] win);
      int n;
      n = $countones(win) - win[4];
      return (n == BIRTH_COUNT) || (win[4] && n == SURVIVE_COUNT);
   endfunction

   task automatic restart_frame();
      win_bits = '0;
      in_c     = 0;
      in_r     = 0;
      out_c    = 0;
      out_r    = 0;
      drain    = 1'b0;
   endtask

   task automatic apply_config(input logic [CSR_INDEX_WIDTH-1:0] idx,
                               input logic [CSR_WIDTH-1:0] value);
      if (idx == REG_GRID_WIDTH) width_reg = value;
      else if (idx == REG_GRID_HEIGHT) height_reg = value;
      else return;
      restart_frame();
   endtask

   // advance one accepted word; queue the cell result it releases, if any
   task automatic step_generation(input logic op, input logic alive);
      int unsigned     w, h, ci, ri;
      logic            cell_bit, up, mid, res, emit;
      logic [2:0]      column;
      cell_result_type r;
      w = span(width_reg, MAX_WIDTH_DEFAULT);
      h = span(height_reg, MAX_HEIGHT_DEFAULT);
      if (op == OP_FLUSH && !drain) return;
      cell_bit = drain ? 1'b0 : alive;
      ci       = in_c;
      ri       = in_r;
      if (ci >= w) ci = 0;

      up  = (ri >= 2) ? upper_bits[ci] : 1'b0;
      mid = (ri >= 1) ? middle_bits[ci] : 1'b0;
      upper_bits[ci]  = mid;
      middle_bits[ci] = cell_bit;
      column = {cell_bit, mid, up};

      emit = 1'b0;
      res  = 1'b0;
      if (ci == 0) begin
         if (ri >= 2) begin
            res  = life_next({3'b000, win_bits[8:3]});
            emit = 1'b1;
         end
         win_bits = {column, 6'b0};
      end else begin
         win_bits = {column, win_bits[8:3]};
         if (ri >= 1) begin
            res  = life_next(win_bits);
            emit = 1'b1;
         end
      end

      if (!drain && ri == h - 1 && ci == w - 1) drain = 1'b1;
      ci++;
      if (ci >= w) begin
         ci = 0;
         ri++;
      end
      in_c = ci;
      in_r = ri;

      if (!emit) return;
      r.next_alive = res;
      r.col        = out_c[COORD_WIDTH-1:0];
      r.row        = out_r[COORD_WIDTH-1:0];
      r.last       = (out_r == h - 1 && out_c == w - 1);
      next_gen_q   = {next_gen_q, r};
      if (r.last) begin
         restart_frame();
      end else begin
         out_c++;
         if (out_c >= w) begin
            out_c = 0;
            out_r++;
         end
      end
   endtask

   always @(posedge clock) begin
      cell_result_type want;
      if (reset) begin
         for (int i = 0; i < MAX_WIDTH_DEFAULT; i++) begin
            upper_bits[i]  = 1'b0;
            middle_bits[i] = 1'b0;
         end
         width_reg  = CSR_WIDTH'(GRID_WIDTH_RESET);
         height_reg = CSR_WIDTH'(GRID_HEIGHT_RESET);
         restart_frame();
         next_gen_q.delete();
      end else begin
         if (rsp_valid && rsp_ready) begin
            if (next_gen_q.size() == 0) begin
               $error("result at row %0d col %0d with nothing expected", rsp_row, rsp_col);
               mismatch_count++;
            end else begin
               want = next_gen_q.pop_front();
               if (rsp_next_alive !== want.next_alive) begin
                  $error("next_alive: expected %0d, got %0d", want.next_alive, rsp_next_alive);
                  mismatch_count++;
               end
               if (rsp_col !== want.col) begin
                  $error("col: expected %0d, got %0d", want.col, rsp_col);
                  mismatch_count++;
               end
               if (rsp_row !== want.row) begin
                  $error("row: expected %0d, got %0d", want.row, rsp_row);
                  mismatch_count++;
               end
               if (rsp_last !== want.last) begin
                  $error("last: expected %0d, got %0d", want.last, rsp_last);
                  mismatch_count++;
               end
            end
         end
         if (csr_write) apply_config(csr_index, csr_wdata);
         if (req_valid && req_ready) step_generation(req_op, req_alive);
      end
      pending_results = next_gen_q.size();
   end

endmodule

FILE: tb/sv/tb_life_generation_stream.sv
`timescale 1ns / 1ps

module tb_life_generation_stream;
   import lgs_pkg::*;

   localparam int MAX_GAP          = 16;
   localparam int SETTLE_CYCLES    = 8;    // fetch + window stage + output register, with margin
   localparam int CYCLE_LIMIT      = 1000000;
   localparam int RANDOM_WORDS     = 860;
   localparam int CLAMP_ROW1_CELLS = 40;   // cells sent into the second row of the wide frame
   // results taken before the long receiver stall: the directed part gives 14, so the
   // stall lands while the wide frame is still streaming its second row
   localparam int HOLD_AFTER       = 24;
   localparam int HOLD_CYCLES      = 400;

   // indexes past the two grid registers; writes there must be dropped
   localparam logic [CSR_INDEX_WIDTH-1:0] REG_SPARE_LO = 2'd2;
   localparam logic [CSR_INDEX_WIDTH-1:0] REG_SPARE_HI = 2'd3;

   logic                       clock = 1'b0;
   logic                       reset = 1'b1;
   logic                       req_valid = 1'b0;
   logic                       req_ready;
   logic                       req_op = OP_CELL;
   logic                       req_alive = 1'b0;
   logic                       rsp_valid;
   logic                       rsp_ready = 1'b0;
   logic                       rsp_next_alive;
   logic [COORD_WIDTH-1:0]     rsp_col;
   logic [COORD_WIDTH-1:0]     rsp_row;
   logic                       rsp_last;
   logic                       csr_write = 1'b0;
   logic [CSR_INDEX_WIDTH-1:0] csr_index = '0;
   logic [CSR_WIDTH-1:0]       csr_wdata = '0;

   int mismatch_count;
   int pending_results;
   int req_gap_max = 0;
   int rsp_gap_max = 0;
   int frame_words = 0;
   int cycle_count = 0;

   always begin
      #10 clock = 1'b1;
      #10 clock = 1'b0;
   end

   life_generation_stream dut (
      .clock          (clock),
      .reset          (reset),
      .req_valid      (req_valid),
      .req_ready      (req_ready),
      .req_op         (req_op),
      .req_alive      (req_alive),
      .rsp_valid      (rsp_valid),
      .rsp_ready      (rsp_ready),
      .rsp_next_alive (rsp_next_alive),
      .rsp_col        (rsp_col),
      .rsp_row        (rsp_row),
      .rsp_last       (rsp_last),
      .csr_write      (csr_write),
      .csr_index      (csr_index),
      .csr_wdata      (csr_wdata)
   );

   life_generation_checker life_check (
      .clock           (clock),
      .reset           (reset),
      .req_valid       (req_valid),
      .req_ready       (req_ready),
      .req_op          (req_op),
      .req_alive       (req_alive),
      .rsp_valid       (rsp_valid),
      .rsp_ready       (rsp_ready),
      .rsp_next_alive  (rsp_next_alive),
      .rsp_col         (rsp_col),
      .rsp_row         (rsp_row),
      .rsp_last        (rsp_last),
      .csr_write       (csr_write),
      .csr_index       (csr_index),
      .csr_wdata       (csr_wdata),
      .mismatch_count  (mismatch_count),
      .pending_results (pending_results)
   );

   // watchdog: stop a hung run
   always @(posedge clock) begin
      cycle_count <= cycle_count + 1;
      if (cycle_count == CYCLE_LIMIT) begin
         $display("end of test: mismatches");
         $finish;
      end
   end

   // receiver: random stalls per result, plus one long hold so the pipe backs up
   initial begin : receiver
      int gap;
      int taken;
      bit held;
      taken = 0;
      held  = 1'b0;
      do @(posedge clock); while (reset);
      forever begin
         if (!held && taken >= HOLD_AFTER) begin
            gap  = HOLD_CYCLES;
            held = 1'b1;
         end else begin
            gap = $urandom_range(0, rsp_gap_max);
         end
         if (gap > 0) begin
            rsp_ready <= 1'b0;
            repeat (gap) @(posedge clock);
         end
         rsp_ready <= 1'b1;
         // hold ready until a result word moves
         do @(posedge clock); while (!rsp_valid);
         taken++;
      end
   end

   // offer one word after a random gap; hold it until accepted
   task automatic send_word(input logic op, input logic alive);
      int gap;
      gap = $urandom_range(0, req_gap_max);
      if (gap > 0) begin
         req_valid <= 1'b0;
         repeat (gap) @(posedge clock);
      end
      req_valid <= 1'b1;
      req_op    <= op;
      req_alive <= alive;
      do @(posedge clock); while (!req_ready);
   endtask

   // drop valid and wait until every predicted result is out and the pipe is quiet
   task automatic settle();
      req_valid <= 1'b0;
      do @(negedge clock); while (pending_results != 0);
      repeat (SETTLE_CYCLES) @(posedge clock);
   endtask

   task automatic write_reg(input logic [CSR_INDEX_WIDTH-1:0] idx,
                            input logic [CSR_WIDTH-1:0] value);
      csr_write <= 1'b1;
      csr_index <= idx;
      csr_wdata <= value;
      @(posedge clock);
      csr_write <= 1'b0;
      @(posedge clock);
   endtask

   // Stream one frame: w*h cells, then w+1 drain words. noise is the percent
   // chance of a stray flush before a cell and of a cell word during the drain.
   // Stop before cell cut_at; at cell pause_at, go idle and poke a spare index.
   task automatic run_frame(input int w, input int h, input int density, input int noise,
                            input int cut_at, input int pause_at);
      for (int q = 0; q < w * h; q++) begin
         if (q == cut_at) return;
         if (q == pause_at) begin
            settle();
            write_reg(($urandom_range(0, 1) == 1) ? REG_SPARE_HI : REG_SPARE_LO,
                      CSR_WIDTH'($urandom_range(0, 2047)));
         end
         if ($urandom_range(0, 99) < noise)
            send_word(OP_FLUSH, $urandom_range(0, 1) == 1);
         send_word(OP_CELL, $urandom_range(0, 99) < density);
         frame_words++;
      end
      for (int q = 0; q <= w; q++) begin
         send_word(($urandom_range(0, 99) < noise) ? OP_CELL : OP_FLUSH,
                   $urandom_range(0, 1) == 1);
         frame_words++;
      end
   endtask

   initial begin : stimulus
      int  w, h, goal, cut_at, pause_at;
      bit  must_write;
      repeat (8) @(posedge clock);
      reset <= 1'b0;
      @(posedge clock);

      // directed: 3x3 blinker, no idling on either side
      write_reg(REG_GRID_WIDTH, 11'd3);
      write_reg(REG_GRID_HEIGHT, 11'd3);
      send_word(OP_FLUSH, 1'b1);           // dropped: nothing to drain yet
      for (int r = 0; r < 3; r++)
         for (int c = 0; c < 3; c++)
            send_word(OP_CELL, c == 1);
      // drain with live cell words mixed in; they must act as flushes
      send_word(OP_CELL, 1'b1);
      send_word(OP_FLUSH, 1'b0);
      send_word(OP_CELL, 1'b1);
      send_word(OP_FLUSH, 1'b1);
      settle();

      // single row: first flush yields nothing, the next four give the row
      write_reg(REG_GRID_HEIGHT, 11'd1);
      write_reg(REG_GRID_WIDTH, 11'd4);
      send_word(OP_CELL, 1'b1);
      send_word(OP_CELL, 1'b1);
      send_word(OP_CELL, 1'b1);
      send_word(OP_CELL, 1'b0);
      repeat (5) send_word(OP_FLUSH, 1'b0);
      settle();

      // register extremes, both sides idling at random
      req_gap_max = MAX_GAP;
      rsp_gap_max = MAX_GAP;
      write_reg(REG_GRID_WIDTH, 11'd0);    // zero acts as one
      write_reg(REG_GRID_HEIGHT, 11'd0);
      run_frame(1, 1, 50, 0, -1, -1);
      settle();
      // full line store width; stop CLAMP_ROW1_CELLS cells into the second row, so the
      // first row fills the whole store and the input wraps at the clamped width
      write_reg(REG_GRID_HEIGHT, 11'd2047); // clamps to the tallest grid
      write_reg(REG_GRID_WIDTH, 11'd2047);  // clamps to the full line store
      run_frame(MAX_WIDTH_DEFAULT, MAX_HEIGHT_DEFAULT, 40, 0,
                MAX_WIDTH_DEFAULT + CLAMP_ROW1_CELLS, -1);
      settle();

      // random frames: mostly small grids, some back to back with no rewrite
      goal       = frame_words + RANDOM_WORDS;
      must_write = 1'b1;
      w          = 1;
      h          = 1;
      while (frame_words < goal) begin
         req_gap_max = ($urandom_range(0, 3) == 0) ? 0 : MAX_GAP;
         rsp_gap_max = ($urandom_range(0, 3) == 0) ? 0 : MAX_GAP;
         if (must_write || $urandom_range(0, 3) != 0) begin
            w = ($urandom_range(0, 15) == 0) ? $urandom_range(13, 40) : $urandom_range(1, 12);
            h = ($urandom_range(0, 15) == 0) ? $urandom_range(9, 24) : $urandom_range(1, 8);
            settle();
            // write zero now and then where the size is one
            if ($urandom_range(0, 1) == 1) begin
               write_reg(REG_GRID_WIDTH,
                         (w == 1 && $urandom_range(0, 1) == 1) ? 11'd0 : CSR_WIDTH'(w));
               write_reg(REG_GRID_HEIGHT,
                         (h == 1 && $urandom_range(0, 1) == 1) ? 11'd0 : CSR_WIDTH'(h));
            end else begin
               write_reg(REG_GRID_HEIGHT, CSR_WIDTH'(h));
               write_reg(REG_GRID_WIDTH, CSR_WIDTH'(w));
            end
         end
         cut_at   = ($urandom_range(0, 7) == 0) ? $urandom_range(0, w * h - 1) : -1;
         pause_at = ($urandom_range(0, 7) == 0) ? $urandom_range(0, w * h - 1) : -1;
         run_frame(w, h, $urandom_range(15, 70),
                   ($urandom_range(0, 3) == 0) ? $urandom_range(1, 10) : 0,
                   cut_at, pause_at);
         // an abandoned frame must be restarted by a register write
         must_write = (cut_at >= 0);
         if (!must_write && $urandom_range(0, 7) == 0)
            send_word(OP_FLUSH, $urandom_range(0, 1) == 1);
      end

      settle();
      @(negedge clock);
      if (mismatch_count == 0 && pending_results == 0) begin
         $display("end of test: clean");
      end else begin
         $display("end of test: mismatches");
      end
      $finish;
   end

endmodule

FILE: sim.f
hdl/lgs_pkg.sv
hdl/lgs_line_store.sv
hdl/lgs_window.sv
hdl/life_generation_stream.sv
hdl/lgs_checker.sv
tb/sv/life_generation_checker.sv
tb/sv/tb_life_generation_stream.sv
